### rtl/core/twsr_pkg.sv
// twsr_pkg: shared types and constants for the two-wire sensor reader
// transfer payload structs, config register indexes and the start pattern
// no dependencies
package twsr_pkg;

    localparam int unsigned CfgIndexWidth = 2;
    localparam int unsigned CfgDataWidth  = 24;

    localparam logic [CfgIndexWidth-1:0] CFG_TICKS_PER_PHASE  = 2'd0;
    localparam logic [CfgIndexWidth-1:0] CFG_READY_POLL_LIMIT = 2'd1;
    localparam logic [CfgIndexWidth-1:0] CFG_SETTLE_TICKS     = 2'd2;

    localparam logic [15:0] TICKS_PER_PHASE_RESET  = 16'd1000;
    localparam logic [15:0] READY_POLL_LIMIT_RESET = 16'd65535;
    localparam logic [23:0] SETTLE_TICKS_RESET     = 24'd500000;

    localparam logic [1:0] OP_IDLE    = 2'd0;
    localparam logic [1:0] OP_MEASURE = 2'd1;
    localparam logic [1:0] OP_RESET   = 2'd2;

    localparam logic [1:0] MODE_TEMPERATURE = 2'd0;
    localparam logic [1:0] MODE_HUMIDITY    = 2'd1;

    localparam logic [7:0] CMD_TEMPERATURE = 8'd3;
    localparam logic [7:0] CMD_HUMIDITY    = 8'd5;
    localparam logic [7:0] CMD_NONE        = 8'd0;

    localparam logic [3:0] RESET_PULSES = 4'd9;

    // start pattern, index is the step number
    localparam logic [7:0] START_CLK = 8'b0011_0110;
    localparam logic [7:0] START_DAT = 8'b0110_0011;

    typedef struct packed {
        logic [1:0] opcode;
        logic [1:0] meas_mode;
        logic       data_sample;
    } twsr_in_t;

    typedef struct packed {
        logic        clock_level;
        logic        data_drive_enable;
        logic        data_level;
        logic        busy_res;
        logic        done_res;
        logic [15:0] reading;
        logic [7:0]  checksum_byte;
        logic [1:0]  error_count;
    } twsr_out_t;

endpackage

### rtl/core/two_wire_sensor_reader.sv
// two_wire_sensor_reader: master side of a bit-banged two-wire sensor link
// one tick per input transfer, one result transfer per tick
// depends on twsr_pkg
//
// Each input transfer is one timing tick and yields exactly one result transfer
// carrying the pin levels driven during that tick and the status after it. The
// sequencer state advances in the same cycle the tick is taken, so a tick can be
// accepted on every clock cycle while in_ready is high; each result is registered.
// A two-entry output buffer (output register plus skid register) lets a tick
// be taken while a finished result is still waiting; in_ready only drops when
// both entries are full. Configuration writes take effect on the next tick.
module two_wire_sensor_reader
    import twsr_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write,
    input  logic [CfgIndexWidth-1:0] cfg_index,
    input  logic [CfgDataWidth-1:0]  cfg_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  twsr_in_t                 in_data,
    output logic                     out_valid,
    input  logic                     out_ready,
    output twsr_out_t                out_data
);

    typedef enum logic [4:0] {
        ST_IDLE     = 5'd0,
        ST_START    = 5'd1,
        ST_WR_HI    = 5'd2,
        ST_WR_LO    = 5'd3,
        ST_WR_ACK   = 5'd4,
        ST_POLL     = 5'd5,
        ST_SETTLE   = 5'd6,
        ST_RD_HI    = 5'd7,
        ST_RD_LO    = 5'd8,
        ST_RDACK_HI = 5'd9,
        ST_RDACK_LO = 5'd10,
        ST_RST_PRE  = 5'd11,
        ST_RST_HI   = 5'd12,
        ST_RST_LO   = 5'd13
    } phase_t;

    logic [15:0] ticks_per_phase_reg;
    logic [15:0] ready_poll_limit_reg;
    logic [23:0] settle_ticks_reg;

    phase_t      phase_reg, phase_next;
    logic [23:0] timer_reg, timer_next;
    logic [3:0]  bit_cnt_reg, bit_cnt_next;
    logic [1:0]  byte_cnt_reg, byte_cnt_next;
    logic [7:0]  shift_reg, shift_next;
    logic [7:0]  command_reg, command_next;
    logic [15:0] value_reg, value_next;
    logic [7:0]  check_reg, check_next;
    logic [1:0]  error_reg, error_next;

    twsr_out_t   out_reg, skid_reg, result;
    logic        out_valid_reg, skid_valid_reg;

    logic        accept_in;
    logic [15:0] phase_len;
    logic [15:0] poll_limit;
    logic [24:0] timer_inc;
    logic        phase_last;
    logic        clk_lvl, drv, dat, busy, done;
    logic [2:0]  bit_idx;

    assign in_ready  = !skid_valid_reg;
    assign accept_in = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign phase_len  = (ticks_per_phase_reg == 16'd0) ? 16'd1 : ticks_per_phase_reg;
    assign poll_limit = (ready_poll_limit_reg == 16'd0) ? 16'd1 : ready_poll_limit_reg;
    assign timer_inc  = {1'b0, timer_reg} + 25'd1;
    assign phase_last = timer_inc >= {9'd0, phase_len};
    assign bit_idx    = bit_cnt_reg[2:0];

    always_comb
    begin
        phase_next   = phase_reg;
        timer_next   = timer_reg;
        bit_cnt_next = bit_cnt_reg;
        byte_cnt_next = byte_cnt_reg;
        shift_next   = shift_reg;
        command_next = command_reg;
        value_next   = value_reg;
        check_next   = check_reg;
        error_next   = error_reg;
        clk_lvl      = 1'b0;
        drv          = 1'b0;
        dat          = 1'b0;
        busy         = 1'b1;
        done         = 1'b0;

        case (phase_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (in_data.opcode == OP_MEASURE)
                begin
                    error_next = 2'd0;
                    if (in_data.meas_mode == MODE_TEMPERATURE)
                        command_next = CMD_TEMPERATURE;
                    else if (in_data.meas_mode == MODE_HUMIDITY)
                        command_next = CMD_HUMIDITY;
                    else
                        command_next = CMD_NONE;
                    shift_next    = 8'd0;
                    byte_cnt_next = 2'd0;
                    bit_cnt_next  = 4'd0;
                    timer_next    = 24'd0;
                    phase_next    = ST_START;
                end
                else if (in_data.opcode == OP_RESET)
                begin
                    bit_cnt_next = 4'd0;
                    timer_next   = 24'd0;
                    phase_next   = ST_RST_PRE;
                end
            end
            ST_START:
            begin
                clk_lvl = START_CLK[bit_idx];
                dat     = START_DAT[bit_idx];
                drv     = 1'b1;
                timer_next = phase_last ? 24'd0 : timer_inc[23:0];
                if (phase_last)
                begin
                    if (bit_idx == 3'd7)
                    begin
                        bit_cnt_next = 4'd0;
                        phase_next   = (command_reg != CMD_NONE) ? ST_WR_HI : ST_POLL;
                    end
                    else
                        bit_cnt_next = bit_cnt_reg + 4'd1;
                end
            end
            ST_WR_HI, ST_WR_LO:
            begin
                clk_lvl = (phase_reg == ST_WR_HI);
                drv     = 1'b1;
                dat     = command_reg[3'd7 - bit_idx];
                timer_next = phase_last ? 24'd0 : timer_inc[23:0];
                if (phase_last)
                begin
                    if (phase_reg == ST_WR_HI)
                        phase_next = ST_WR_LO;
                    else if (bit_idx == 3'd7)
                    begin
                        bit_cnt_next = 4'd0;
                        phase_next   = ST_WR_ACK;
                    end
                    else
                    begin
                        bit_cnt_next = bit_cnt_reg + 4'd1;
                        phase_next   = ST_WR_HI;
                    end
                end
            end
            ST_WR_ACK:
            begin
                clk_lvl = 1'b1;
                timer_next = phase_last ? 24'd0 : timer_inc[23:0];
                if (phase_last)
                begin
                    error_next = error_reg + {1'b0, in_data.data_sample};
                    phase_next = ST_POLL;
                end
            end
            ST_POLL:
            begin
                if (!in_data.data_sample || (timer_inc[23:0] >= {8'd0, poll_limit}))
                begin
                    if (in_data.data_sample)
                        error_next = error_reg + 2'd1;
                    timer_next    = 24'd0;
                    bit_cnt_next  = 4'd0;
                    byte_cnt_next = 2'd0;
                    shift_next    = 8'd0;
                    phase_next    = (settle_ticks_reg != 24'd0) ? ST_SETTLE : ST_RD_HI;
                end
                else
                    timer_next = timer_inc[23:0];
            end
            ST_SETTLE:
            begin
                if (timer_inc[23:0] >= settle_ticks_reg)
                begin
                    timer_next = 24'd0;
                    phase_next = ST_RD_HI;
                end
                else
                    timer_next = timer_inc[23:0];
            end
            ST_RD_HI:
            begin
                clk_lvl = 1'b1;
                timer_next = phase_last ? 24'd0 : timer_inc[23:0];
                if (phase_last)
                begin
                    shift_next = {shift_reg[6:0], in_data.data_sample};
                    phase_next = ST_RD_LO;
                end
            end
            ST_RD_LO:
            begin
                timer_next = phase_last ? 24'd0 : timer_inc[23:0];
                if (phase_last)
                begin
                    if (bit_idx == 3'd7)
                    begin
                        bit_cnt_next = 4'd0;
                        if (byte_cnt_reg == 2'd0)
                            value_next = {shift_reg, 8'd0};
                        else if (byte_cnt_reg == 2'd1)
                            value_next = {value_reg[15:8], shift_reg};
                        else
                            check_next = shift_reg;
                        phase_next = ST_RDACK_HI;
                    end
                    else
                    begin
                        bit_cnt_next = bit_cnt_reg + 4'd1;
                        phase_next   = ST_RD_HI;
                    end
                end
            end
            ST_RDACK_HI:
            begin
                clk_lvl = 1'b1;
                drv     = 1'b1;
                dat     = (byte_cnt_reg >= 2'd2);
                timer_next = phase_last ? 24'd0 : timer_inc[23:0];
                if (phase_last)
                    phase_next = ST_RDACK_LO;
            end
            ST_RDACK_LO:
            begin
                drv = 1'b1;
                dat = 1'b1;
                timer_next = phase_last ? 24'd0 : timer_inc[23:0];
                if (phase_last)
                begin
                    if (byte_cnt_reg >= 2'd2)
                    begin
                        byte_cnt_next = 2'd0;
                        phase_next    = ST_IDLE;
                        done          = 1'b1;
                    end
                    else
                    begin
                        byte_cnt_next = byte_cnt_reg + 2'd1;
                        shift_next    = 8'd0;
                        phase_next    = ST_RD_HI;
                    end
                end
            end
            ST_RST_PRE, ST_RST_HI, ST_RST_LO:
            begin
                clk_lvl = (phase_reg == ST_RST_HI);
                drv     = 1'b1;
                dat     = 1'b1;
                timer_next = phase_last ? 24'd0 : timer_inc[23:0];
                if (phase_last)
                begin
                    if (phase_reg == ST_RST_PRE)
                    begin
                        bit_cnt_next = 4'd0;
                        phase_next   = ST_RST_HI;
                    end
                    else if (phase_reg == ST_RST_HI)
                        phase_next = ST_RST_LO;
                    else if ({1'b0, bit_cnt_reg} + 5'd1 >= {1'b0, RESET_PULSES})
                    begin
                        bit_cnt_next = 4'd0;
                        phase_next   = ST_IDLE;
                    end
                    else
                    begin
                        bit_cnt_next = bit_cnt_reg + 4'd1;
                        phase_next   = ST_RST_HI;
                    end
                end
            end
            default:
            begin
                busy       = 1'b0;
                phase_next = ST_IDLE;
            end
        endcase

        result.clock_level       = clk_lvl;
        result.data_drive_enable = drv;
        result.data_level        = dat;
        result.busy_res          = busy;
        result.done_res          = done;
        result.reading           = value_next;
        result.checksum_byte     = check_next;
        result.error_count       = error_next;
    end

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_per_phase_reg  <= TICKS_PER_PHASE_RESET;
            ready_poll_limit_reg <= READY_POLL_LIMIT_RESET;
            settle_ticks_reg     <= SETTLE_TICKS_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_TICKS_PER_PHASE:  ticks_per_phase_reg  <= cfg_data[15:0];
                CFG_READY_POLL_LIMIT: ready_poll_limit_reg <= cfg_data[15:0];
                CFG_SETTLE_TICKS:     settle_ticks_reg     <= cfg_data;
                default:              ;
            endcase
        end
    end

    // sequencer state, advances once per accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= ST_IDLE;
            timer_reg    <= 24'd0;
            bit_cnt_reg  <= 4'd0;
            byte_cnt_reg <= 2'd0;
            shift_reg    <= 8'd0;
            command_reg  <= 8'd0;
            value_reg    <= 16'd0;
            check_reg    <= 8'd0;
            error_reg    <= 2'd0;
        end
        else if (accept_in)
        begin
            phase_reg    <= phase_next;
            timer_reg    <= timer_next;
            bit_cnt_reg  <= bit_cnt_next;
            byte_cnt_reg <= byte_cnt_next;
            shift_reg    <= shift_next;
            command_reg  <= command_next;
            value_reg    <= value_next;
            check_reg    <= check_next;
            error_reg    <= error_next;
        end
    end

    // output register plus skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_valid_reg && !out_ready)
        begin
            if (accept_in)
                skid_valid_reg <= 1'b1;
        end
        else if (skid_valid_reg)
        begin
            out_valid_reg  <= 1'b1;
            skid_valid_reg <= 1'b0;
        end
        else
            out_valid_reg <= accept_in;
    end

    always_ff @(posedge clk)
    begin
        if (out_valid_reg && !out_ready)
        begin
            if (accept_in)
                skid_reg <= result;
        end
        else if (skid_valid_reg)
            out_reg <= skid_reg;
        else if (accept_in)
            out_reg <= result;
    end

endmodule
